@@ rtl/ltt_pkg.sv @@
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and helpers for the lambda term tokenizer
// Holds the channel payload structs, the controller/datapath command and
// status bundles, the state and class enums and character helpers.
// ----------------------------------------------------------------------------
package ltt_pkg;

  // Name buffer geometry.
  localparam int unsigned MaxName  = 32;
  localparam int unsigned NameIdxW = (MaxName > 1) ? $clog2(MaxName) : 1;
  localparam int unsigned NameLenW = $clog2(MaxName + 1);

  localparam int unsigned AccW = 31;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  // Token kinds as seen on the output channel.
  localparam logic [2:0] TK_NAME   = 3'd0;
  localparam logic [2:0] TK_NUMBER = 3'd1;
  localparam logic [2:0] TK_DOT    = 3'd2;
  localparam logic [2:0] TK_LAMBDA = 3'd3;
  localparam logic [2:0] TK_OPEN   = 3'd4;
  localparam logic [2:0] TK_CLOSE  = 3'd5;
  localparam logic [2:0] TK_END    = 3'd6;

  // Input commands.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Character codes of interest.
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      token_kind;
    logic [AccW-1:0] number_value;
    logic [7:0]      name_char;
    logic [4:0]      char_index;
    logic            token_end;
    logic            overflow;
    logic            last;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_NUM
  } mode_e;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_PUNCT,
    CLS_SPACE,
    CLS_DIGIT,
    CLS_NAME
  } cls_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NAME,
    ST_NUM,
    ST_TAIL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic absorb;      // take the input request into the word state now
    logic latch;       // hold the input request until its results are out
    logic emit_name;   // send the current name character
    logic emit_num;    // send the number token
    logic emit_tail;   // send the punctuation or end token
    logic clear_word;  // word finished: back to idle
    logic tail_apply;  // apply the held non-token character to the word state
  } ltt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_e mode;
    logic  in_results;  // the input request causes results
    logic  pend_token;  // the held request gives a token of its own
    logic  name_last;   // the character on hand is the last of the name
    logic  out_free;    // output register can take a result this cycle
  } ltt_stat_t;

  // Character class of one request.
  function automatic cls_e classify(input logic cmd, input logic [7:0] c);
    cls_e r;
    if (cmd == CMD_END) begin
      r = CLS_END;
    end else if (c == CH_DOT || c == CH_BSLASH || c == CH_OPEN || c == CH_CLOSE) begin
      r = CLS_PUNCT;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      r = CLS_SPACE;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      r = CLS_DIGIT;
    end else begin
      r = CLS_NAME;
    end
    return r;
  endfunction

  // Token kind of a punctuation or end request.
  function automatic logic [2:0] tail_kind(input logic cmd, input logic [7:0] c);
    logic [2:0] k;
    if (cmd == CMD_END) begin
      k = TK_END;
    end else if (c == CH_DOT) begin
      k = TK_DOT;
    end else if (c == CH_BSLASH) begin
      k = TK_LAMBDA;
    end else if (c == CH_OPEN) begin
      k = TK_OPEN;
    end else begin
      k = TK_CLOSE;
    end
    return k;
  endfunction

endpackage

@@ rtl/ltt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ltt_ctrl: tokenizer sequencer
// Decides per request whether it is absorbed at once or needs a flush
// sequence, and steps the datapath through name, number and tail results.
// ----------------------------------------------------------------------------
module ltt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ltt_pkg::ltt_stat_t stat_i,
  output ltt_pkg::ltt_cmd_t  cmd_o
);
  import ltt_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (stat_i.in_results) begin
            cmd_o.latch = 1'b1;
            unique case (stat_i.mode)
              MODE_NAME: state_d = ST_NAME;
              MODE_NUM:  state_d = ST_NUM;
              default:   state_d = ST_TAIL;
            endcase
          end else begin
            cmd_o.absorb = 1'b1;
          end
        end
      end
      ST_NAME: begin
        if (stat_i.out_free) begin
          cmd_o.emit_name = 1'b1;
          if (stat_i.name_last) begin
            cmd_o.clear_word = 1'b1;
            state_d          = ST_TAIL;
          end
        end
      end
      ST_NUM: begin
        if (stat_i.out_free) begin
          cmd_o.emit_num   = 1'b1;
          cmd_o.clear_word = 1'b1;
          state_d          = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (stat_i.pend_token) begin
          if (stat_i.out_free) begin
            cmd_o.emit_tail = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.tail_apply = 1'b1;
          state_d          = ST_IDLE;
        end
      end
    endcase
  end

endmodule

@@ rtl/ltt_dpath.sv @@
// ----------------------------------------------------------------------------
// ltt_dpath: tokenizer datapath
// Word state, name buffer memory, decimal accumulator, the held request
// and the output register.
// ----------------------------------------------------------------------------
module ltt_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ltt_pkg::out_item_t out_data_o,
  input  ltt_pkg::ltt_cmd_t  cmd_i,
  output ltt_pkg::ltt_stat_t stat_o
);
  import ltt_pkg::*;

  mode_e               mode_q, mode_d;
  logic [NameLenW-1:0] len_q, len_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic                ovf_q, ovf_d;
  in_item_t            pend_q;
  logic [NameIdxW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]          rdata_q;
  logic [7:0]          name_mem [MaxName];
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  cls_e                in_cls, pend_cls, ap_cls;
  logic [7:0]          ap_char;
  logic                apply;
  logic                name_wr;
  logic [3:0]          digit;
  logic [AccW+3:0]     acc_next;
  logic                acc_sat;
  logic                out_free;
  logic                emit_any;
  logic                name_last;

  assign in_cls   = classify(in_data_i.command, in_data_i.char_code);
  assign pend_cls = classify(pend_q.command, pend_q.char_code);
  assign out_free = !out_valid_q || !out_stall_i;

  // The input causes results if it is a token itself or it ends a live word.
  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.out_free   = out_free;
    stat_o.pend_token = (pend_cls == CLS_END) || (pend_cls == CLS_PUNCT);
    stat_o.name_last  = name_last;
    stat_o.in_results = 1'b0;
    unique case (in_cls)
      CLS_END, CLS_PUNCT: stat_o.in_results = 1'b1;
      CLS_SPACE:          stat_o.in_results = (mode_q != MODE_IDLE);
      CLS_DIGIT:          stat_o.in_results = (mode_q == MODE_NAME);
      CLS_NAME:           stat_o.in_results = (mode_q == MODE_NUM);
      default:            stat_o.in_results = 1'b0;
    endcase
  end

  assign name_last = (NameLenW'(rd_idx_q) + NameLenW'(1)) == len_q;

  // Character that goes into the word: the live input or the held one.
  assign apply   = cmd_i.absorb || cmd_i.tail_apply;
  assign ap_cls  = cmd_i.absorb ? in_cls : pend_cls;
  assign ap_char = cmd_i.absorb ? in_data_i.char_code : pend_q.char_code;

  // Accumulator step: acc * 10 + digit, saturated at the 31-bit maximum.
  assign digit    = 4'(ap_char - CH_ZERO);
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (AccW + 4)'(digit);
  assign acc_sat  = |acc_next[AccW+3:AccW];

  assign name_wr = apply && (ap_cls == CLS_NAME) && (len_q < NameLenW'(MaxName));

  // Word state update.
  always_comb begin
    mode_d = mode_q;
    len_d  = len_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    if (cmd_i.clear_word) begin
      mode_d = MODE_IDLE;
      len_d  = '0;
      acc_d  = '0;
      ovf_d  = 1'b0;
    end else if (apply) begin
      unique case (ap_cls)
        CLS_DIGIT: begin
          mode_d = MODE_NUM;
          if (acc_sat) begin
            acc_d = AccMax;
            ovf_d = 1'b1;
          end else begin
            acc_d = acc_next[AccW-1:0];
          end
        end
        CLS_NAME: begin
          mode_d = MODE_NAME;
          if (len_q < NameLenW'(MaxName)) begin
            len_d = len_q + NameLenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
    end
  end

  // Held request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      pend_q <= in_data_i;
    end
  end

  // Read pointer: the data for rd_idx_q sits in rdata_q, the next one is
  // fetched as soon as the current character is sent.
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.latch) begin
      rd_idx_d = '0;
    end else if (cmd_i.emit_name) begin
      rd_idx_d = rd_idx_q + NameIdxW'(1);
    end
  end

  // Name buffer memory, one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (name_wr) begin
      name_mem[len_q[NameIdxW-1:0]] <= ap_char;
    end
    rdata_q  <= name_mem[rd_idx_d];
    rd_idx_q <= rd_idx_d;
  end

  // Output register contents.
  assign emit_any = cmd_i.emit_name || cmd_i.emit_num || cmd_i.emit_tail;

  always_comb begin
    out_d       = '0;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = emit_any;
    end
    if (cmd_i.emit_name) begin
      out_d.token_kind = TK_NAME;
      out_d.name_char  = rdata_q;
      out_d.char_index = 5'(rd_idx_q);
      out_d.token_end  = name_last;
      out_d.overflow   = ovf_q;
      out_d.last       = name_last && !stat_o.pend_token;
    end else if (cmd_i.emit_num) begin
      out_d.token_kind   = TK_NUMBER;
      out_d.number_value = acc_q;
      out_d.token_end    = 1'b1;
      out_d.overflow     = ovf_q;
      out_d.last         = !stat_o.pend_token;
    end else begin
      out_d.token_kind = tail_kind(pend_q.command, pend_q.char_code);
      out_d.token_end  = 1'b1;
      out_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit_any) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/lambda_term_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// lambda_term_tokenizer_core: character stream to lambda term tokens
// Splits a byte stream into names, decimal numbers, punctuation and an end
// token. A name leaves as one result per stored character.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------
//   in      | request   | in_valid_i / in_stall_o   | ltt_pkg::in_item_t
//   out     | result    | out_valid_o / out_stall_i | ltt_pkg::out_item_t
//
// A request that only extends a word, or whitespace while idle, is absorbed
// at once. A request that ends a word or is a token holds the input off:
// it is captured, then the name is sent one result per character or the
// number as one result, and a closing step follows.
// The sequence is set by the single read port of the name buffer.
// Reset is asynchronous and active low; the name buffer needs no clearing.
// An output stall holds the result register and pauses the sequence.
module lambda_term_tokenizer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ltt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ltt_pkg::out_item_t out_data_o
);
  import ltt_pkg::*;

  ltt_cmd_t  cmd;
  ltt_stat_t stat;

  // Sequencer.
  ltt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Word state, name buffer and output register.
  ltt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ tb/sv/lambda_term_tokenizer_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lambda_term_tokenizer_core_tb: self-checking test of the term tokenizer
// Drives character and end-of-input requests through the valid/stall input
// channel. A behavioral model of the tokenizer predicts the token results of
// each accepted request, and a monitor compares every result field by field.
// Directed sequences run with a busy receiver and cover punctuation,
// character class borders, long names and saturating numbers. Random
// lambda-term fragments follow, first with a bursty sender, then with no idling at all.
// ----------------------------------------------------------------------------
module lambda_term_tokenizer_core_tb;
  import ltt_pkg::*;

  typedef enum logic [1:0] {
    SORT_PUNCT,
    SORT_SPACE,
    SORT_DIGIT,
    SORT_WORD
  } char_sort_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned counted_requests = 0;
  int unsigned fail_count = 0;

  // Tokens still owed by the block, oldest first.
  out_item_t pending_tokens[$];
  out_item_t step_tokens[$];
  out_item_t want_token;

  // Word state of the behavioral model.
  mode_e             word_mode = MODE_IDLE;
  logic [7:0]        name_buf [MaxName];
  int unsigned       name_len  = 0;
  logic [AccW-1:0]   num_acc   = '0;
  logic              word_ovf  = 1'b0;

  lambda_term_tokenizer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic char_sort_e char_sort(logic [7:0] c);
    if (c == CH_DOT || c == CH_BSLASH || c == CH_OPEN || c == CH_CLOSE) return SORT_PUNCT;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return SORT_SPACE;
    if (c >= CH_ZERO && c <= CH_NINE) return SORT_DIGIT;
    return SORT_WORD;
  endfunction

  function automatic void emit_token(logic [2:0] kind, logic [AccW-1:0] val,
                                     logic [7:0] ch, logic [4:0] idx,
                                     logic tend, logic ovf);
    out_item_t tok;
    tok.token_kind   = kind;
    tok.number_value = val;
    tok.name_char    = ch;
    tok.char_index   = idx;
    tok.token_end    = tend;
    tok.overflow     = ovf;
    tok.last         = 1'b0;
    step_tokens.insert(step_tokens.size(), tok);
  endfunction

  // Send out the word in progress, if any, and return to idle.
  function automatic void close_word();
    if (word_mode == MODE_NAME) begin
      for (int unsigned i = 0; i < name_len; i++) begin
        emit_token(TK_NAME, '0, name_buf[i], 5'(i), (i + 1 == name_len), word_ovf);
      end
    end else if (word_mode == MODE_NUM) begin
      emit_token(TK_NUMBER, num_acc, 8'h00, 5'd0, 1'b1, word_ovf);
    end
    word_mode = MODE_IDLE;
    name_len  = 0;
    num_acc   = '0;
    word_ovf  = 1'b0;
  endfunction

  // Work out the tokens that one accepted request causes.
  function automatic void predict_tokens(in_item_t req);
    out_item_t   tail;
    logic [2:0]  kind;
    logic [31:0] digit;
    logic [31:0] acc_wide;
    step_tokens.delete();
    if (req.command == CMD_END) begin
      close_word();
      emit_token(TK_END, '0, 8'h00, 5'd0, 1'b1, 1'b0);
    end else begin
      case (char_sort(req.char_code))
        SORT_PUNCT: begin
          case (req.char_code)
            CH_DOT:    kind = TK_DOT;
            CH_BSLASH: kind = TK_LAMBDA;
            CH_OPEN:   kind = TK_OPEN;
            default:   kind = TK_CLOSE;
          endcase
          close_word();
          emit_token(kind, '0, 8'h00, 5'd0, 1'b1, 1'b0);
        end
        SORT_SPACE: begin
          close_word();
        end
        SORT_DIGIT: begin
          if (word_mode != MODE_NUM) close_word();
          word_mode = MODE_NUM;
          digit     = 32'(req.char_code - CH_ZERO);
          acc_wide  = {1'b0, num_acc};
          // Saturate rather than wrap once the value no longer fits.
          if (acc_wide > ({1'b0, AccMax} - digit) / 32'd10) begin
            num_acc  = AccMax;
            word_ovf = 1'b1;
          end else begin
            acc_wide = acc_wide * 32'd10 + digit;
            num_acc  = acc_wide[AccW-1:0];
          end
        end
        default: begin
          if (word_mode != MODE_NAME) close_word();
          word_mode = MODE_NAME;
          // Characters beyond the buffer are dropped and flagged.
          if (name_len < MaxName) begin
            name_buf[name_len] = req.char_code;
            name_len++;
          end else begin
            word_ovf = 1'b1;
          end
        end
      endcase
    end
    if (step_tokens.size() != 0) begin
      tail      = step_tokens.pop_back();
      tail.last = 1'b1;
      step_tokens.insert(step_tokens.size(), tail);
    end
    foreach (step_tokens[k]) pending_tokens.insert(pending_tokens.size(), step_tokens[k]);
  endfunction

  task automatic check_field(string fname, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest pending token.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall == 1'b0) begin
      if (pending_tokens.size() == 0) begin
        $error("token result with none pending: kind %0d", out_data_o.token_kind);
        fail_count++;
      end else begin
        want_token = pending_tokens.pop_front();
        check_field("token_kind", want_token.token_kind, out_data_o.token_kind);
        check_field("number_value", want_token.number_value, out_data_o.number_value);
        check_field("name_char", want_token.name_char, out_data_o.name_char);
        check_field("char_index", want_token.char_index, out_data_o.char_index);
        check_field("token_end", want_token.token_end, out_data_o.token_end);
        check_field("overflow", want_token.overflow, out_data_o.overflow);
        check_field("last", want_token.last, out_data_o.last);
      end
    end
  end

  // Present one request and wait for its acceptance; called at a clock edge.
  task automatic send_request(logic cmd, logic [7:0] ch);
    in_item_t req;
    bit       counted;
    req.command   = cmd;
    req.char_code = ch;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    // Whitespace while idle leaves the block untouched.
    counted = !(cmd == CMD_CHAR && char_sort(ch) == SORT_SPACE && word_mode == MODE_IDLE);
    if (counted) counted_requests++;
    predict_tokens(req);
  endtask

  // Hold the sender off until every pending token has come out.
  task automatic wait_for_tokens();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_request(CMD_CHAR, s[k]);
  endtask

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    if ($urandom_range(3) != 0) begin
      c = 8'h61 + 8'($urandom_range(25));
    end else begin
      do c = 8'($urandom_range(255)); while (char_sort(c) != SORT_WORD);
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(3))
      0:       return CH_DOT;
      1:       return CH_BSLASH;
      2:       return CH_OPEN;
      default: return CH_CLOSE;
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    logic [7:0] c;
    if ($urandom_range(5) == 5) c = CH_SPACE;
    else c = CH_TAB + 8'($urandom_range(4));
    return c;
  endfunction

  task automatic send_name(int unsigned len);
    for (int unsigned k = 0; k < len; k++) send_request(CMD_CHAR, pick_name_char());
  endtask

  task automatic send_number(int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_request(CMD_CHAR, CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  // All four punctuation tokens, a name ended by a digit, end of input.
  task automatic test_punctuation();
    send_text("\\x.(x1 y)");
    send_request(CMD_END, 8'h00);
  endtask

  // Idle whitespace and end, borders of each character class, high bytes.
  task automatic test_char_classes();
    logic [7:0] probe [12] = '{8'h00, 8'h08, CH_TAB, 8'h2F, 8'h3A, 8'h0E, CH_CR,
                               CH_ZERO, CH_NINE, CH_NINE, 8'hFF, 8'h80};
    send_request(CMD_CHAR, CH_SPACE);
    send_request(CMD_END, 8'hFF);
    foreach (probe[k]) send_request(CMD_CHAR, probe[k]);
    send_request(CMD_END, 8'h00);
  endtask

  // A name one character longer than the buffer, ended by a token.
  task automatic test_long_name();
    send_name(MaxName + 1);
    send_request(CMD_CHAR, CH_CLOSE);
  endtask

  // The largest value and one past it, then end of input.
  task automatic test_number_saturation();
    send_text("2147483647 2147483648 ");
    send_request(CMD_END, 8'($urandom_range(255)));
  endtask

  // Random lambda-term fragments with some raw noise mixed in.
  task automatic run_random_terms(int unsigned target);
    int unsigned pick;
    counted_requests = 0;
    while (counted_requests < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_name(($urandom_range(9) == 0) ? $urandom_range(10, 7) : $urandom_range(4, 1));
      end else if (pick < 48) begin
        send_number(($urandom_range(9) == 0) ? $urandom_range(11, 10) : $urandom_range(3, 1));
      end else if (pick < 72) begin
        send_request(CMD_CHAR, pick_punct());
      end else if (pick < 84) begin
        send_request(CMD_CHAR, pick_space());
      end else if (pick < 90) begin
        send_request(CMD_END, 8'($urandom_range(255)));
      end else begin
        send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 52;
    test_punctuation();
    test_char_classes();
    test_long_name();
    test_number_saturation();
    wait_for_tokens();

    send_idle_pct = 52;
    recv_idle_pct = 8;
    run_random_terms(12);
    wait_for_tokens();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_terms(12);
    wait_for_tokens();

    // Let a full name sequence pass to catch stray results.
    repeat (MaxName + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
